@@ rtl/core/j2_perturbation_acceleration_defines.svh @@
// ----------------------------------------------------------------------------
// J2 perturbation acceleration: assertion macros
// Implication and next-cycle implication checks, empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef J2_PERTURBATION_ACCELERATION_DEFINES_SVH
`define J2_PERTURBATION_ACCELERATION_DEFINES_SVH
`ifndef SYNTH
`define J2PA_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("j2pa assertion failed");
`define J2PA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("j2pa assertion failed");
`else
`define J2PA_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define J2PA_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/j2pa_pkg.sv @@
// ----------------------------------------------------------------------------
// J2 perturbation acceleration: package
// Widths, stage numbers, register indexes and the side-band record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package j2pa_pkg;

	localparam int POS_W   = 32;
	localparam int ACC_W   = 48;
	localparam int COEF_W  = 53;
	localparam int STEPS   = 32;
	localparam int WM_A_W  = 128;
	localparam int WM_P_W  = 160;
	localparam int RND_W   = 161;

	localparam int LAST_ST  = 82;
	localparam int ST_ZERO  = 3;
	localparam int ST_SHAMT = 5;
	localparam int ST_T     = 39;
	localparam int ST_K     = 71;

	localparam logic REG_ENABLE = 1'b0;
	localparam logic REG_COEF   = 1'b1;

	localparam logic [COEF_W-1:0] COEF_RESET = 53'd6131070000000000;
	localparam logic [63:0] POS_LIM = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic [63:0] NEG_LIM = 64'h0000_8000_0000_0000;

	typedef struct packed {
		logic [31:0] xm;
		logic [31:0] ym;
		logic [31:0] zm;
		logic        xn;
		logic        yn;
		logic        zn;
		logic        zero;
		logic [7:0]  shamt;
		logic [30:0] t;
		logic [31:0] kxy_mag;
		logic        kxy_neg;
		logic [31:0] kz_mag;
		logic        kz_neg;
	} side_t;

endpackage

`default_nettype wire

@@ rtl/core/j2_perturbation_acceleration.sv @@
// ----------------------------------------------------------------------------
// J2 perturbation acceleration: top level
// Earth oblateness perturbing acceleration from an inertial position vector.
// ----------------------------------------------------------------------------
// Position transactions enter on s_axis (x, y, z as 32-bit signed metres) and
// acceleration transactions leave on m_axis (x, y, z as 48-bit signed values
// in units of 2^-40 m/s^2, flags saturated and degenerate on tuser).
// The cfg channel writes register 0 (enable) and register 1 (the 53-bit
// coefficient) and is always ready; the user must write it only while the
// block is idle, and the block does not enforce this. A new position may be
// accepted in every cycle while s_axis_tready is high: one transaction per
// cycle. Data pass the 32-stage square root, then the 32-stage reciprocal
// divider, the chain of three wide multipliers and the rounding shifter.
// Reset empties the pipeline and the output register and loads the enable
// and coefficient registers with their defaults.
// While m_axis is stalled the output register holds its result and the
// pipeline keeps moving until a valid result reaches its last stage; then the
// whole pipeline freezes and s_axis_tready falls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "j2_perturbation_acceleration_defines.svh"

module j2_perturbation_acceleration import j2pa_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [95:0]       s_axis_tdata,   // pos_x, pos_y, pos_z
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic      [143:0]      m_axis_tdata,   // accel_x, accel_y, accel_z
	output logic      [1:0]        m_axis_tuser,   // saturated, degenerate
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic              cfg_index,
	input  wire logic [COEF_W-1:0] cfg_data
);

	logic              enable_q;
	logic [COEF_W-1:0] coef_q;
	logic              en;
	logic [LAST_ST:1]  vld_s;
	side_t             side_s  [1:LAST_ST];
	side_t             side_nx [1:LAST_ST];
	side_t             in_side;
	logic [31:0]       px, py, pz;

	logic [63:0] sq_x_s2, sq_y_s2, sq_z_s2;
	logic [63:0] r2_sum;
	logic [63:0] r2_s3, z2_s3, r2_s4, z2_s4, r2_s5, z2_s5;
	logic [4:0]  clen [4];
	logic [4:0]  clen_s4 [4];
	logic [6:0]  blen;
	logic signed [8:0] sv, hv, sh9;
	logic [7:0]  sft_s5;
	logic [7:0]  nsft;
	logic [63:0] shr_r, shl_r, shr_z, shl_z;
	logic [31:0] r2n_s6, z2n_s6;
	logic [31:0] root, t_q, u;
	logic [33:0] t5, kxy_d, kz_d;
	logic [63:0] uu_s71, uu2_s72, u5p_s73;
	logic [31:0] u_s71, u_s72;

	logic [WM_P_W-1:0] p1, pxy, pz_k;
	logic [WM_P_W-1:0] prod [3];
	logic [RND_W-1:0]  rnd  [3];
	logic [RND_W-1:0]  rnd_s80 [3];
	logic [RND_W-1:0]  cs_s81 [3];
	logic [RND_W-1:0]  fs_s82 [3];
	logic [RND_W-1:0]  rbit;
	logic [2:0]        pn, kn;
	logic [63:0]       mag [3];
	logic [63:0]       lim [3];
	logic [ACC_W-1:0]  acc [3];
	logic              sat;
	logic [143:0]      out_data;
	logic [1:0]        out_user;
	logic              out_valid_q;
	logic [143:0]      out_data_q;
	logic [1:0]        out_user_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			coef_q   <= COEF_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_COEF:   coef_q   <= cfg_data;
			endcase
		end
	end

	assign cfg_ready     = 1'b1;
	assign en            = !vld_s[LAST_ST] || !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAST_ST-1:1], s_axis_tvalid};
		end
	end

	// side-band record
	always_comb begin
		px = s_axis_tdata[31:0];
		py = s_axis_tdata[63:32];
		pz = s_axis_tdata[95:64];
		in_side    = '0;
		in_side.xn = px[31];
		in_side.yn = py[31];
		in_side.zn = pz[31];
		in_side.xm = px[31] ? (~px + 32'd1) : px;
		in_side.ym = py[31] ? (~py + 32'd1) : py;
		in_side.zm = pz[31] ? (~pz + 32'd1) : pz;

		r2_sum = sq_x_s2 + sq_y_s2 + sq_z_s2;

		t5    = {3'b000, side_s[ST_K-1].t} + {1'b0, side_s[ST_K-1].t, 2'b00};
		kxy_d = t5 - 34'h0_4000_0000;
		kz_d  = t5 - 34'h0_C000_0000;

		side_nx[1] = in_side;
		for (int i = 2; i <= LAST_ST; i++) begin
			side_nx[i] = side_s[i-1];
		end
		side_nx[ST_ZERO].zero  = (r2_sum == 64'd0);
		side_nx[ST_SHAMT].shamt = sh9[7:0];
		side_nx[ST_T].t        = t_q[30:0];
		side_nx[ST_K].kxy_neg  = (t5 < 34'h0_4000_0000);
		side_nx[ST_K].kxy_mag  = side_nx[ST_K].kxy_neg ? (32'd0 - kxy_d[31:0]) : kxy_d[31:0];
		side_nx[ST_K].kz_neg   = (t5 < 34'h0_C000_0000);
		side_nx[ST_K].kz_mag   = side_nx[ST_K].kz_neg ? (32'd0 - kz_d[31:0]) : kz_d[31:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s <= side_nx;
		end
	end

	// squares, sum of squares, normalisation
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			clen[c] = '0;
			for (int b = 0; b < 16; b++) begin
				if (r2_s3[16*c + b]) clen[c] = 5'(b + 1);
			end
		end
		blen = '0;
		for (int c = 0; c < 4; c++) begin
			if (clen_s4[c] != 5'd0) blen = 7'(16 * c) + {2'b00, clen_s4[c]};
		end
		sv = $signed({2'b00, blen}) - 9'sd32;
		if (sv[0]) sv = sv + 9'sd1;
		hv  = sv >>> 1;
		sh9 = 9'sd75 + 9'sd5 * hv;
		nsft  = 8'd0 - sft_s5;
		shr_r = r2_s5 >> sft_s5[6:0];
		shl_r = r2_s5 << nsft[6:0];
		shr_z = z2_s5 >> sft_s5[6:0];
		shl_z = z2_s5 << nsft[6:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_x_s2 <= 64'(side_s[1].xm) * 64'(side_s[1].xm);
			sq_y_s2 <= 64'(side_s[1].ym) * 64'(side_s[1].ym);
			sq_z_s2 <= 64'(side_s[1].zm) * 64'(side_s[1].zm);
			r2_s3   <= r2_sum;
			z2_s3   <= sq_z_s2;
			r2_s4   <= r2_s3;
			z2_s4   <= z2_s3;
			clen_s4 <= clen;
			r2_s5   <= r2_s4;
			z2_s5   <= z2_s4;
			sft_s5  <= sv[7:0];
			r2n_s6  <= sft_s5[7] ? shl_r[31:0] : shr_r[31:0];
			z2n_s6  <= sft_s5[7] ? shl_z[31:0] : shr_z[31:0];
		end
	end

	// ratio, root and reciprocal
	j2pa_div u_div_t (
		.clk      (clk),
		.en       (en),
		.dividend ({2'b00, z2n_s6, 30'd0}),
		.divisor  (r2n_s6),
		.quotient (t_q)
	);

	j2pa_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.v    ({2'b00, r2n_s6, 30'd0}),
		.root (root)
	);

	j2pa_div u_div_u (
		.clk      (clk),
		.en       (en),
		.dividend (64'h3FFF_FFFF_FFFF_FFFF),
		.divisor  (root),
		.quotient (u)
	);

	// fifth power of the reciprocal
	always_ff @(posedge clk) begin
		if (en) begin
			uu_s71  <= 64'(u) * 64'(u);
			u_s71   <= u;
			uu2_s72 <= 64'(uu_s71[63:32]) * 64'(uu_s71[63:32]);
			u_s72   <= u_s71;
			u5p_s73 <= 64'(uu2_s72[63:32]) * 64'(u_s72);
		end
	end

	// product chain
	j2pa_wmul u_mul_c (
		.clk (clk),
		.en  (en),
		.a   ({75'd0, coef_q}),
		.b   (u5p_s73[63:32]),
		.p   (p1)
	);

	j2pa_wmul u_mul_kxy (
		.clk (clk),
		.en  (en),
		.a   (p1[WM_A_W-1:0]),
		.b   (side_s[75].kxy_mag),
		.p   (pxy)
	);

	j2pa_wmul u_mul_kz (
		.clk (clk),
		.en  (en),
		.a   (p1[WM_A_W-1:0]),
		.b   (side_s[75].kz_mag),
		.p   (pz_k)
	);

	j2pa_wmul u_mul_px (
		.clk (clk),
		.en  (en),
		.a   (pxy[WM_A_W-1:0]),
		.b   (side_s[77].xm),
		.p   (prod[0])
	);

	j2pa_wmul u_mul_py (
		.clk (clk),
		.en  (en),
		.a   (pxy[WM_A_W-1:0]),
		.b   (side_s[77].ym),
		.p   (prod[1])
	);

	j2pa_wmul u_mul_pz (
		.clk (clk),
		.en  (en),
		.a   (pz_k[WM_A_W-1:0]),
		.b   (side_s[77].zm),
		.p   (prod[2])
	);

	// round half away from zero, shift, saturate
	always_comb begin
		rbit = '0;
		if (side_s[79].shamt != 8'd0) begin
			rbit[side_s[79].shamt - 8'd1] = 1'b1;
		end
		for (int c = 0; c < 3; c++) begin
			rnd[c] = {prod[c][RND_W-11:0], 10'd0} + rbit;
		end

		pn = {side_s[LAST_ST].zn, side_s[LAST_ST].yn, side_s[LAST_ST].xn};
		kn = {side_s[LAST_ST].kz_neg, side_s[LAST_ST].kxy_neg, side_s[LAST_ST].kxy_neg};
		sat = 1'b0;
		for (int c = 0; c < 3; c++) begin
			lim[c] = (pn[c] == kn[c]) ? NEG_LIM : POS_LIM;
			mag[c] = fs_s82[c][63:0];
			if ((|fs_s82[c][RND_W-1:64]) || (mag[c] > lim[c])) begin
				mag[c] = lim[c];
				sat    = 1'b1;
			end
			acc[c] = (pn[c] == kn[c]) ? (~mag[c][ACC_W-1:0] + 48'd1) : mag[c][ACC_W-1:0];
		end

		if (!enable_q) begin
			out_data = '0;
			out_user = '0;
		end else if (side_s[LAST_ST].zero) begin
			out_data = '0;
			out_user = 2'b10;
		end else begin
			out_data = {acc[2], acc[1], acc[0]};
			out_user = {1'b0, sat};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rnd_s80 <= rnd;
			for (int c = 0; c < 3; c++) begin
				cs_s81[c] <= rnd_s80[c] >> {side_s[80].shamt[7:5], 5'd0};
				fs_s82[c] <= cs_s81[c] >> side_s[81].shamt[4:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (vld_s[LAST_ST] && en) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s[LAST_ST] && en) begin
			out_data_q <= out_data;
			out_user_q <= out_user;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	`J2PA_ASSERT_IMPL(a_deg_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata == '0 && !m_axis_tuser[0])
	`J2PA_ASSERT_IMPL(a_flags_excl, clk, arst_n, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]))
	`J2PA_ASSERT_NEXT(a_accept_enters, clk, arst_n, s_axis_tvalid && s_axis_tready, vld_s[1])
	`J2PA_ASSERT_NEXT(a_stall_freezes, clk, arst_n, !en, $stable(vld_s))

endmodule

`default_nettype wire

@@ rtl/core/j2pa_sqrt.sv @@
// ----------------------------------------------------------------------------
// J2 perturbation acceleration: pipelined square root
// Floor square root of a 64-bit word, one result bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module j2pa_sqrt import j2pa_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [63:0] v,
	output logic      [31:0] root
);

	logic [63:0] v_s    [STEPS];
	logic [33:0] rem_s  [STEPS];
	logic [31:0] root_s [STEPS];
	logic [63:0] v_in   [STEPS];
	logic [33:0] rem_in [STEPS];
	logic [31:0] rt_in  [STEPS];
	logic [35:0] acc    [STEPS];
	logic [35:0] trial  [STEPS];
	logic [35:0] diff   [STEPS];
	logic [63:0] v_nx   [STEPS];
	logic [33:0] rem_nx [STEPS];
	logic [31:0] rt_nx  [STEPS];

	always_comb begin
		for (int j = 0; j < STEPS; j++) begin
			if (j == 0) begin
				v_in[j]   = v;
				rem_in[j] = '0;
				rt_in[j]  = '0;
			end else begin
				v_in[j]   = v_s[j-1];
				rem_in[j] = rem_s[j-1];
				rt_in[j]  = root_s[j-1];
			end
			acc[j]   = {rem_in[j], v_in[j][63:62]};
			trial[j] = {2'b00, rt_in[j], 2'b01};
			diff[j]  = acc[j] - trial[j];
			v_nx[j]  = {v_in[j][61:0], 2'b00};
			if (acc[j] >= trial[j]) begin
				rem_nx[j] = diff[j][33:0];
				rt_nx[j]  = {rt_in[j][30:0], 1'b1};
			end else begin
				rem_nx[j] = acc[j][33:0];
				rt_nx[j]  = {rt_in[j][30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s    <= v_nx;
			rem_s  <= rem_nx;
			root_s <= rt_nx;
		end
	end

	assign root = root_s[STEPS-1];

endmodule

`default_nettype wire

@@ rtl/core/j2pa_div.sv @@
// ----------------------------------------------------------------------------
// J2 perturbation acceleration: pipelined divider
// 64 by 32 bit restoring division, one quotient bit per stage; the upper
// half of the dividend must lie below the divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module j2pa_div import j2pa_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [63:0] dividend,
	input  wire logic [31:0] divisor,
	output logic      [31:0] quotient
);

	logic [31:0] d_s    [STEPS];
	logic [31:0] dv_s   [STEPS];
	logic [31:0] rem_s  [STEPS];
	logic [31:0] q_s    [STEPS];
	logic [31:0] d_in   [STEPS];
	logic [31:0] dv_in  [STEPS];
	logic [31:0] rem_in [STEPS];
	logic [31:0] q_in   [STEPS];
	logic [32:0] r      [STEPS];
	logic [32:0] diff   [STEPS];
	logic [31:0] d_nx   [STEPS];
	logic [31:0] rem_nx [STEPS];
	logic [31:0] q_nx   [STEPS];

	always_comb begin
		for (int j = 0; j < STEPS; j++) begin
			if (j == 0) begin
				d_in[j]   = dividend[31:0];
				dv_in[j]  = divisor;
				rem_in[j] = dividend[63:32];
				q_in[j]   = '0;
			end else begin
				d_in[j]   = d_s[j-1];
				dv_in[j]  = dv_s[j-1];
				rem_in[j] = rem_s[j-1];
				q_in[j]   = q_s[j-1];
			end
			r[j]    = {rem_in[j], d_in[j][31]};
			diff[j] = r[j] - {1'b0, dv_in[j]};
			d_nx[j] = {d_in[j][30:0], 1'b0};
			if (r[j] >= {1'b0, dv_in[j]}) begin
				rem_nx[j] = diff[j][31:0];
				q_nx[j]   = {q_in[j][30:0], 1'b1};
			end else begin
				rem_nx[j] = r[j][31:0];
				q_nx[j]   = {q_in[j][30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s   <= d_nx;
			dv_s  <= dv_in;
			rem_s <= rem_nx;
			q_s   <= q_nx;
		end
	end

	assign quotient = q_s[STEPS-1];

endmodule

`default_nettype wire

@@ rtl/core/j2pa_wmul.sv @@
// ----------------------------------------------------------------------------
// J2 perturbation acceleration: wide multiplier
// 128 by 32 bit product in two stages: four registered partial products,
// then one registered sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module j2pa_wmul import j2pa_pkg::*; (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [WM_A_W-1:0] a,
	input  wire logic [31:0]       b,
	output logic      [WM_P_W-1:0] p
);

	logic [63:0]       pp_s1 [4];
	logic [WM_P_W-1:0] p_s2;
	logic [WM_P_W-1:0] even;
	logic [WM_P_W-1:0] odd;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				pp_s1[k] <= 64'(a[32*k +: 32]) * 64'(b);
			end
			p_s2 <= even + odd;
		end
	end

	always_comb begin
		even = {32'd0, pp_s1[2], pp_s1[0]};
		odd  = {pp_s1[3], pp_s1[1], 32'd0};
	end

	assign p = p_s2;

endmodule

`default_nettype wire
